@@ rtl/mid_pkg.sv @@
// Shared types, codes and decode tables for the MIPS instruction decoder.
// Depends on nothing; every other file but mid_codes_pkg imports it.
package mid_pkg;

	localparam int WORD_W = 32;
	localparam int REG_W  = 5;
	localparam int IMM_W  = 16;
	localparam int JMP_W  = 26;
	localparam int FLAG_W = 17;

	localparam logic [5:0] OPC_SPECIAL = 6'd0;

	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_R       = 2'd1,
		FMT_I       = 2'd2,
		FMT_J       = 2'd3
	} fmt_t;

	typedef enum logic [4:0] {
		ALU_SLL    = 5'd0,
		ALU_SRL    = 5'd1,
		ALU_SRA    = 5'd2,
		ALU_SLLV   = 5'd3,
		ALU_SRLV   = 5'd4,
		ALU_SRAV   = 5'd5,
		ALU_JR     = 5'd6,
		ALU_JALR   = 5'd7,
		ALU_MOVZ   = 5'd8,
		ALU_MOVN   = 5'd9,
		ALU_BREAK  = 5'd10,
		ALU_MFHI   = 5'd11,
		ALU_MTHI   = 5'd12,
		ALU_MFLO   = 5'd13,
		ALU_MTLO   = 5'd14,
		ALU_MULT   = 5'd15,
		ALU_MULTU  = 5'd16,
		ALU_DIV    = 5'd17,
		ALU_DIVU   = 5'd18,
		ALU_ADDU   = 5'd19,
		ALU_SUB    = 5'd20,
		ALU_SUBU   = 5'd21,
		ALU_AND    = 5'd22,
		ALU_OR     = 5'd23,
		ALU_XOR    = 5'd24,
		ALU_NOR    = 5'd25,
		ALU_SLT    = 5'd26,
		ALU_SLTU   = 5'd27,
		ALU_PASS_S = 5'd28,
		ALU_ADD    = 5'd29,
		ALU_LUI    = 5'd30
	} alu_op_t;

	typedef enum logic [2:0] {
		MEM_NONE  = 3'd0,
		MEM_BYTE  = 3'd1,
		MEM_HALF  = 3'd2,
		MEM_WORD  = 3'd3,
		MEM_BYTEU = 3'd4,
		MEM_HALFU = 3'd5,
		MEM_CACHE = 3'd6
	} mem_t;

	localparam logic [FLAG_W-1:0] F_SUP     = FLAG_W'(1) << 0;
	localparam logic [FLAG_W-1:0] F_ALUSRC  = FLAG_W'(1) << 1;
	localparam logic [FLAG_W-1:0] F_REGWR   = FLAG_W'(1) << 2;
	localparam logic [FLAG_W-1:0] F_AREQ_RS = FLAG_W'(1) << 3;
	localparam logic [FLAG_W-1:0] F_ZEXT    = FLAG_W'(1) << 4;
	localparam logic [FLAG_W-1:0] F_MEMRD   = FLAG_W'(1) << 5;
	localparam logic [FLAG_W-1:0] F_MEM     = FLAG_W'(1) << 6;
	localparam logic [FLAG_W-1:0] F_MEMWR   = FLAG_W'(1) << 7;
	localparam logic [FLAG_W-1:0] F_MSTORE  = FLAG_W'(1) << 8;
	localparam logic [FLAG_W-1:0] F_AREQ_RT = FLAG_W'(1) << 9;
	localparam logic [FLAG_W-1:0] F_REGD    = FLAG_W'(1) << 10;
	localparam logic [FLAG_W-1:0] F_BREQ_RS = FLAG_W'(1) << 11;
	localparam logic [FLAG_W-1:0] F_PC8_RT  = FLAG_W'(1) << 12;
	localparam logic [FLAG_W-1:0] F_RD_HILO = FLAG_W'(1) << 13;
	localparam logic [FLAG_W-1:0] F_WR_HILO = FLAG_W'(1) << 14;
	localparam logic [FLAG_W-1:0] F_PC_R31  = FLAG_W'(1) << 15;
	localparam logic [FLAG_W-1:0] F_BREQ_RT = FLAG_W'(1) << 16;

	localparam logic [FLAG_W-1:0] G_I   = F_SUP | F_ALUSRC | F_REGWR | F_AREQ_RS;
	localparam logic [FLAG_W-1:0] G_IZ  = G_I | F_ZEXT;
	localparam logic [FLAG_W-1:0] G_LD  = F_SUP | F_ALUSRC | F_REGWR | F_MEMRD | F_MEM
		| F_AREQ_RS;
	localparam logic [FLAG_W-1:0] G_ST  = F_SUP | F_ALUSRC | F_MEMWR | F_MEM | F_MSTORE
		| F_AREQ_RS | F_AREQ_RT;
	localparam logic [FLAG_W-1:0] G_STD = F_SUP | F_REGD | F_REGWR | F_AREQ_RS | F_AREQ_RT;
	localparam logic [FLAG_W-1:0] G_ST2 = F_SUP | F_AREQ_RS | F_AREQ_RT;
	localparam logic [FLAG_W-1:0] G_S   = F_SUP | F_AREQ_RS;
	localparam logic [FLAG_W-1:0] G_D   = F_SUP | F_REGD | F_REGWR;
	localparam logic [FLAG_W-1:0] G_SD  = F_SUP | F_REGD | F_REGWR | F_AREQ_RS;

	typedef struct packed {
		fmt_t              fmt;
		alu_op_t           alu;
		mem_t              mem;
		logic [FLAG_W-1:0] flags;
	} dec_entry_t;

	typedef struct packed {
		logic [1:0]        format_class;
		logic [4:0]        alu_operation;
		logic [2:0]        memory_access;
		logic [FLAG_W-1:0] control_flags;
		logic [REG_W-1:0]  source_reg;
		logic [REG_W-1:0]  target_reg;
		logic [REG_W-1:0]  dest_reg;
		logic [REG_W-1:0]  shift_amount;
		logic [IMM_W-1:0]  immediate_value;
		logic [JMP_W-1:0]  jump_target;
	} result_t;

	localparam dec_entry_t DEC_NONE = '{FMT_UNKNOWN, ALU_SLL, MEM_NONE, '0};

	function automatic dec_entry_t mk(fmt_t f, alu_op_t a, mem_t m, logic [FLAG_W-1:0] fl);
		dec_entry_t e;
		e.fmt   = f;
		e.alu   = a;
		e.mem   = m;
		e.flags = fl;
		return e;
	endfunction

	function automatic dec_entry_t funct_lookup(logic [5:0] fn);
		dec_entry_t e;
		unique case (fn)
			6'd0:    e = mk(FMT_R, ALU_SLL,   MEM_NONE, G_STD);
			6'd2:    e = mk(FMT_R, ALU_SRL,   MEM_NONE, G_SD);
			6'd3:    e = mk(FMT_R, ALU_SRA,   MEM_NONE, G_SD);
			6'd4:    e = mk(FMT_R, ALU_SLLV,  MEM_NONE, G_STD);
			6'd6:    e = mk(FMT_R, ALU_SRLV,  MEM_NONE, G_STD);
			6'd7:    e = mk(FMT_R, ALU_SRAV,  MEM_NONE, G_STD);
			6'd8:    e = mk(FMT_R, ALU_JR,    MEM_NONE, F_SUP | F_BREQ_RS);
			6'd9:    e = mk(FMT_R, ALU_JALR,  MEM_NONE,
				F_SUP | F_REGD | F_REGWR | F_BREQ_RS | F_PC8_RT);
			6'd10:   e = mk(FMT_R, ALU_MOVZ,  MEM_NONE, G_STD);
			6'd11:   e = mk(FMT_R, ALU_MOVN,  MEM_NONE, G_STD);
			6'd13:   e = mk(FMT_R, ALU_BREAK, MEM_NONE, F_SUP);
			6'd16:   e = mk(FMT_R, ALU_MFHI,  MEM_NONE, G_D | F_RD_HILO);
			6'd17:   e = mk(FMT_R, ALU_MTHI,  MEM_NONE, G_S | F_WR_HILO);
			6'd18:   e = mk(FMT_R, ALU_MFLO,  MEM_NONE, G_D | F_RD_HILO);
			6'd19:   e = mk(FMT_R, ALU_MTLO,  MEM_NONE, G_S | F_WR_HILO);
			6'd24:   e = mk(FMT_R, ALU_MULT,  MEM_NONE, G_ST2 | F_WR_HILO);
			6'd25:   e = mk(FMT_R, ALU_MULTU, MEM_NONE, G_ST2 | F_WR_HILO);
			6'd26:   e = mk(FMT_R, ALU_DIV,   MEM_NONE, G_ST2 | F_WR_HILO);
			6'd27:   e = mk(FMT_R, ALU_DIVU,  MEM_NONE, G_ST2 | F_WR_HILO);
			6'd32:   e = mk(FMT_R, ALU_ADDU,  MEM_NONE, G_STD);
			6'd33:   e = mk(FMT_R, ALU_ADDU,  MEM_NONE, G_STD);
			6'd34:   e = mk(FMT_R, ALU_SUB,   MEM_NONE, G_STD);
			6'd35:   e = mk(FMT_R, ALU_SUBU,  MEM_NONE, G_STD);
			6'd36:   e = mk(FMT_R, ALU_AND,   MEM_NONE, G_STD);
			6'd37:   e = mk(FMT_R, ALU_OR,    MEM_NONE, G_STD);
			6'd38:   e = mk(FMT_R, ALU_XOR,   MEM_NONE, G_STD);
			6'd39:   e = mk(FMT_R, ALU_NOR,   MEM_NONE, G_STD);
			6'd42:   e = mk(FMT_R, ALU_SLT,   MEM_NONE, G_STD);
			6'd43:   e = mk(FMT_R, ALU_SLTU,  MEM_NONE, G_STD);
			default: e = DEC_NONE;
		endcase
		return e;
	endfunction

	function automatic dec_entry_t op_lookup(logic [5:0] opc);
		dec_entry_t e;
		unique case (opc)
			6'd1:    e = mk(FMT_I, ALU_SLL,    MEM_NONE, F_SUP | F_BREQ_RS);
			6'd2:    e = mk(FMT_J, ALU_SLL,    MEM_NONE, F_SUP);
			6'd3:    e = mk(FMT_J, ALU_PASS_S, MEM_NONE, F_SUP | F_PC_R31 | F_REGWR);
			6'd4:    e = mk(FMT_I, ALU_SLL,    MEM_NONE, F_SUP | F_BREQ_RS | F_BREQ_RT);
			6'd5:    e = mk(FMT_I, ALU_SLL,    MEM_NONE, F_SUP | F_BREQ_RS | F_BREQ_RT);
			6'd6:    e = mk(FMT_I, ALU_SLL,    MEM_NONE, F_SUP | F_BREQ_RS);
			6'd7:    e = mk(FMT_I, ALU_SLL,    MEM_NONE, F_SUP | F_BREQ_RS);
			6'd8:    e = mk(FMT_I, ALU_ADD,    MEM_NONE, G_I);
			6'd9:    e = mk(FMT_I, ALU_ADDU,   MEM_NONE, G_I);
			6'd10:   e = mk(FMT_I, ALU_SLT,    MEM_NONE, G_I);
			6'd11:   e = mk(FMT_I, ALU_SLTU,   MEM_NONE, G_I);
			6'd12:   e = mk(FMT_I, ALU_AND,    MEM_NONE, G_IZ);
			6'd13:   e = mk(FMT_I, ALU_OR,     MEM_NONE, G_IZ);
			6'd14:   e = mk(FMT_I, ALU_XOR,    MEM_NONE, G_IZ);
			6'd15:   e = mk(FMT_I, ALU_LUI,    MEM_NONE, G_I);
			6'd32:   e = mk(FMT_I, ALU_ADDU,   MEM_BYTE,  G_LD);
			6'd33:   e = mk(FMT_I, ALU_ADDU,   MEM_HALF,  G_LD);
			6'd34:   e = mk(FMT_I, ALU_ADDU,   MEM_NONE,  F_MEM);
			6'd35:   e = mk(FMT_I, ALU_ADDU,   MEM_WORD,  G_LD);
			6'd36:   e = mk(FMT_I, ALU_ADDU,   MEM_BYTEU, G_LD);
			6'd37:   e = mk(FMT_I, ALU_ADDU,   MEM_HALFU, G_LD);
			6'd38:   e = mk(FMT_I, ALU_ADDU,   MEM_NONE,  F_MEM);
			6'd40:   e = mk(FMT_I, ALU_ADDU,   MEM_BYTE,  G_ST);
			6'd41:   e = mk(FMT_I, ALU_ADDU,   MEM_HALF,  G_ST);
			6'd42:   e = mk(FMT_I, ALU_ADDU,   MEM_NONE,  F_MEM | F_MSTORE);
			6'd43:   e = mk(FMT_I, ALU_ADDU,   MEM_WORD,  G_ST);
			6'd46:   e = mk(FMT_I, ALU_ADDU,   MEM_NONE,  F_MEM | F_MSTORE);
			6'd47:   e = mk(FMT_I, ALU_ADDU,   MEM_CACHE,
				F_SUP | F_ALUSRC | F_MEM | F_MSTORE);
			default: e = DEC_NONE;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/mid_in_if.sv @@
// Input channel: one instruction word per item, valid/ready handshake.
// Depends on mid_pkg for the word width.
interface mid_in_if import mid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink   (input valid, input instruction_word, output ready);
endinterface

@@ rtl/mid_out_if.sv @@
// Output channel: one decoded result per item, valid/ready handshake.
// Depends on mid_pkg for the field widths.
interface mid_out_if import mid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        format_class;
	logic [4:0]        alu_operation;
	logic [2:0]        memory_access;
	logic [FLAG_W-1:0] control_flags;
	logic [REG_W-1:0]  source_reg;
	logic [REG_W-1:0]  target_reg;
	logic [REG_W-1:0]  dest_reg;
	logic [REG_W-1:0]  shift_amount;
	logic [IMM_W-1:0]  immediate_value;
	logic [JMP_W-1:0]  jump_target;

	modport source (output valid, output format_class, output alu_operation,
		output memory_access, output control_flags, output source_reg, output target_reg,
		output dest_reg, output shift_amount, output immediate_value, output jump_target,
		input ready);
	modport sink   (input valid, input format_class, input alu_operation,
		input memory_access, input control_flags, input source_reg, input target_reg,
		input dest_reg, input shift_amount, input immediate_value, input jump_target,
		output ready);
endinterface

@@ rtl/mid_decode.sv @@
// Combinational decode of one instruction word through the two-level table.
// Depends on mid_pkg for the tables and the result type.
module mid_decode import mid_pkg::*; (
	input  logic [WORD_W-1:0] word,
	output result_t           result
);

	logic [5:0] opc;
	logic [5:0] fn;
	dec_entry_t entry;

	assign opc = word[31:26];
	assign fn  = word[5:0];

	always_comb begin
		if (opc == OPC_SPECIAL) begin
			entry = funct_lookup(fn);
		end else begin
			entry = op_lookup(opc);
		end
	end

	always_comb begin
		result.format_class    = entry.fmt;
		result.alu_operation   = entry.alu;
		result.memory_access   = entry.mem;
		result.control_flags   = entry.flags;
		result.source_reg      = word[25:21];
		result.target_reg      = word[20:16];
		result.dest_reg        = word[15:11];
		result.shift_amount    = word[10:6];
		result.immediate_value = word[15:0];
		result.jump_target     = word[25:0];
	end

endmodule

@@ rtl/mips_instruction_decoder.sv @@
// MIPS32 instruction decoder, top level: input register, decode, result register.
// Depends on mid_pkg, mid_in_if, mid_out_if and mid_decode.
//
// Usage:
//   req carries one 32-bit instruction word per item; rsp carries the decoded
//   format, ALU operation, memory access kind, control flags and raw fields.
//   An item moves on a rising edge of clk where valid and ready are both high.
//   An item accepted on req is held in the input register while the decode
//   table feeds the result register, whose output drives rsp.valid and the
//   decoded fields. Throughput is one item per cycle while rsp is not
//   stalled; the table lookup is the only logic between the two registers.
//   When rsp is stalled, the result register holds, the input register
//   keeps taking an item until it is also full, and req.ready then drops.
//   Asynchronous reset (arst_n low) empties both registers; rsp.valid is low
//   and req.ready is high right after reset.
module mips_instruction_decoder import mid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mid_in_if.sink    req,
	mid_out_if.source rsp
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              valid_s2;
	result_t           result_s2;
	result_t           dec_result;
	logic              advance_s2;

	assign advance_s2 = !valid_s2 || rsp.ready;
	assign req.ready  = !valid_s1 || advance_s2;

	mid_decode u_decode (
		.word   (word_s1),
		.result (dec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			word_s1 <= req.instruction_word;
		end
		if (advance_s2 && valid_s1) begin
			result_s2 <= dec_result;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.format_class    = result_s2.format_class;
	assign rsp.alu_operation   = result_s2.alu_operation;
	assign rsp.memory_access   = result_s2.memory_access;
	assign rsp.control_flags   = result_s2.control_flags;
	assign rsp.source_reg      = result_s2.source_reg;
	assign rsp.target_reg      = result_s2.target_reg;
	assign rsp.dest_reg        = result_s2.dest_reg;
	assign rsp.shift_amount    = result_s2.shift_amount;
	assign rsp.immediate_value = result_s2.immediate_value;
	assign rsp.jump_target     = result_s2.jump_target;

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s2) |=> (valid_s1 && $stable(word_s1)))
		else $error("input register lost its item during a stall");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance_s2) |=> valid_s2)
		else $error("decoded item did not reach the result register");

	a_unknown_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.format_class == FMT_UNKNOWN) |->
		(result_s2.control_flags == '0 && result_s2.alu_operation == ALU_SLL
		&& result_s2.memory_access == MEM_NONE))
		else $error("unknown encoding decoded with nonzero controls");

	a_mem_is_itype: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.memory_access != MEM_NONE) |->
		(result_s2.format_class == FMT_I && (result_s2.control_flags & F_MEM) != '0))
		else $error("memory access on a non I-type decode");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted item not held in the input register");

endmodule

@@ test/mid_codes_pkg.sv @@
`timescale 1ns / 100ps
// Opcode and funct encodings of the MIPS32 instruction words used by the decoder bench.
// Depends on nothing; the checker and the bench top import it.
package mid_codes_pkg;

	localparam logic [5:0] OP_REGIMM = 6'd1;
	localparam logic [5:0] OP_J      = 6'd2;
	localparam logic [5:0] OP_JAL    = 6'd3;
	localparam logic [5:0] OP_BEQ    = 6'd4;
	localparam logic [5:0] OP_BNE    = 6'd5;
	localparam logic [5:0] OP_BLEZ   = 6'd6;
	localparam logic [5:0] OP_BGTZ   = 6'd7;
	localparam logic [5:0] OP_ADDI   = 6'd8;
	localparam logic [5:0] OP_ADDIU  = 6'd9;
	localparam logic [5:0] OP_SLTI   = 6'd10;
	localparam logic [5:0] OP_SLTIU  = 6'd11;
	localparam logic [5:0] OP_ANDI   = 6'd12;
	localparam logic [5:0] OP_ORI    = 6'd13;
	localparam logic [5:0] OP_XORI   = 6'd14;
	localparam logic [5:0] OP_LUI    = 6'd15;
	localparam logic [5:0] OP_COP0   = 6'd16;
	localparam logic [5:0] OP_LB     = 6'd32;
	localparam logic [5:0] OP_LH     = 6'd33;
	localparam logic [5:0] OP_LWL    = 6'd34;
	localparam logic [5:0] OP_LW     = 6'd35;
	localparam logic [5:0] OP_LBU    = 6'd36;
	localparam logic [5:0] OP_LHU    = 6'd37;
	localparam logic [5:0] OP_LWR    = 6'd38;
	localparam logic [5:0] OP_SB     = 6'd40;
	localparam logic [5:0] OP_SH     = 6'd41;
	localparam logic [5:0] OP_SWL    = 6'd42;
	localparam logic [5:0] OP_SW     = 6'd43;
	localparam logic [5:0] OP_SWR    = 6'd46;
	localparam logic [5:0] OP_CACHE  = 6'd47;
	localparam logic [5:0] OP_TOP    = 6'd63;

	localparam logic [5:0] FN_SLL    = 6'd0;
	localparam logic [5:0] FN_MOVCI  = 6'd1;
	localparam logic [5:0] FN_SRL    = 6'd2;
	localparam logic [5:0] FN_SRA    = 6'd3;
	localparam logic [5:0] FN_SLLV   = 6'd4;
	localparam logic [5:0] FN_SRLV   = 6'd6;
	localparam logic [5:0] FN_SRAV   = 6'd7;
	localparam logic [5:0] FN_JR     = 6'd8;
	localparam logic [5:0] FN_JALR   = 6'd9;
	localparam logic [5:0] FN_MOVZ   = 6'd10;
	localparam logic [5:0] FN_MOVN   = 6'd11;
	localparam logic [5:0] FN_BREAK  = 6'd13;
	localparam logic [5:0] FN_MFHI   = 6'd16;
	localparam logic [5:0] FN_MTHI   = 6'd17;
	localparam logic [5:0] FN_MFLO   = 6'd18;
	localparam logic [5:0] FN_MTLO   = 6'd19;
	localparam logic [5:0] FN_MULT   = 6'd24;
	localparam logic [5:0] FN_MULTU  = 6'd25;
	localparam logic [5:0] FN_DIV    = 6'd26;
	localparam logic [5:0] FN_DIVU   = 6'd27;
	localparam logic [5:0] FN_ADD    = 6'd32;
	localparam logic [5:0] FN_ADDU   = 6'd33;
	localparam logic [5:0] FN_SUB    = 6'd34;
	localparam logic [5:0] FN_SUBU   = 6'd35;
	localparam logic [5:0] FN_AND    = 6'd36;
	localparam logic [5:0] FN_OR     = 6'd37;
	localparam logic [5:0] FN_XOR    = 6'd38;
	localparam logic [5:0] FN_NOR    = 6'd39;
	localparam logic [5:0] FN_SLT    = 6'd42;
	localparam logic [5:0] FN_SLTU   = 6'd43;
	localparam logic [5:0] FN_PAST   = 6'd44;
	localparam logic [5:0] FN_TOP    = 6'd63;

endpackage

@@ test/mid_decode_checker.sv @@
`timescale 1ns / 100ps
// Decode checker: watches both channels, predicts each decoded result and compares it.
// Depends on mid_pkg, mid_codes_pkg, mid_in_if and mid_out_if.
module mid_decode_checker import mid_pkg::*; import mid_codes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mid_in_if    in_ch,
	mid_out_if   out_ch,
	output int   fail_count,
	output int   pending
);

	result_t decoded_q[$];

	function automatic result_t decode_word(input logic [WORD_W-1:0] word);
		result_t r;
		logic [5:0] opc;
		logic [5:0] fn;
		opc = word[31:26];
		fn = word[5:0];
		r = '0;
		r.source_reg = word[25:21];
		r.target_reg = word[20:16];
		r.dest_reg = word[15:11];
		r.shift_amount = word[10:6];
		r.immediate_value = word[15:0];
		r.jump_target = word[25:0];
		if (opc == OPC_SPECIAL) begin
			r.format_class = FMT_R;
			r.control_flags = G_STD;
			case (fn)
				FN_SLL:   r.alu_operation = ALU_SLL;
				FN_SRL:   begin r.alu_operation = ALU_SRL; r.control_flags = G_SD; end
				FN_SRA:   begin r.alu_operation = ALU_SRA; r.control_flags = G_SD; end
				FN_SLLV:  r.alu_operation = ALU_SLLV;
				FN_SRLV:  r.alu_operation = ALU_SRLV;
				FN_SRAV:  r.alu_operation = ALU_SRAV;
				FN_JR:    begin
					r.alu_operation = ALU_JR;
					r.control_flags = F_SUP | F_BREQ_RS;
				end
				FN_JALR:  begin
					r.alu_operation = ALU_JALR;
					r.control_flags = F_SUP | F_REGD | F_REGWR | F_BREQ_RS | F_PC8_RT;
				end
				FN_MOVZ:  r.alu_operation = ALU_MOVZ;
				FN_MOVN:  r.alu_operation = ALU_MOVN;
				FN_BREAK: begin r.alu_operation = ALU_BREAK; r.control_flags = F_SUP; end
				FN_MFHI:  begin r.alu_operation = ALU_MFHI; r.control_flags = G_D | F_RD_HILO; end
				FN_MFLO:  begin r.alu_operation = ALU_MFLO; r.control_flags = G_D | F_RD_HILO; end
				FN_MTHI:  begin r.alu_operation = ALU_MTHI; r.control_flags = G_S | F_WR_HILO; end
				FN_MTLO:  begin r.alu_operation = ALU_MTLO; r.control_flags = G_S | F_WR_HILO; end
				FN_MULT:  begin
					r.alu_operation = ALU_MULT;
					r.control_flags = G_ST2 | F_WR_HILO;
				end
				FN_MULTU: begin
					r.alu_operation = ALU_MULTU;
					r.control_flags = G_ST2 | F_WR_HILO;
				end
				FN_DIV:   begin r.alu_operation = ALU_DIV; r.control_flags = G_ST2 | F_WR_HILO; end
				FN_DIVU:  begin
					r.alu_operation = ALU_DIVU;
					r.control_flags = G_ST2 | F_WR_HILO;
				end
				FN_ADD, FN_ADDU: r.alu_operation = ALU_ADDU;
				FN_SUB:   r.alu_operation = ALU_SUB;
				FN_SUBU:  r.alu_operation = ALU_SUBU;
				FN_AND:   r.alu_operation = ALU_AND;
				FN_OR:    r.alu_operation = ALU_OR;
				FN_XOR:   r.alu_operation = ALU_XOR;
				FN_NOR:   r.alu_operation = ALU_NOR;
				FN_SLT:   r.alu_operation = ALU_SLT;
				FN_SLTU:  r.alu_operation = ALU_SLTU;
				default:  begin r.format_class = FMT_UNKNOWN; r.control_flags = '0; end
			endcase
		end else begin
			r.format_class = FMT_I;
			r.alu_operation = ALU_ADDU;
			case (opc)
				OP_REGIMM, OP_BLEZ, OP_BGTZ: begin
					r.alu_operation = ALU_SLL;
					r.control_flags = F_SUP | F_BREQ_RS;
				end
				OP_BEQ, OP_BNE: begin
					r.alu_operation = ALU_SLL;
					r.control_flags = F_SUP | F_BREQ_RS | F_BREQ_RT;
				end
				OP_J:     begin
					r.format_class = FMT_J;
					r.alu_operation = ALU_SLL;
					r.control_flags = F_SUP;
				end
				OP_JAL:   begin
					r.format_class = FMT_J;
					r.alu_operation = ALU_PASS_S;
					r.control_flags = F_SUP | F_PC_R31 | F_REGWR;
				end
				OP_ADDI:  begin r.alu_operation = ALU_ADD; r.control_flags = G_I; end
				OP_ADDIU: r.control_flags = G_I;
				OP_SLTI:  begin r.alu_operation = ALU_SLT; r.control_flags = G_I; end
				OP_SLTIU: begin r.alu_operation = ALU_SLTU; r.control_flags = G_I; end
				OP_ANDI:  begin r.alu_operation = ALU_AND; r.control_flags = G_IZ; end
				OP_ORI:   begin r.alu_operation = ALU_OR; r.control_flags = G_IZ; end
				OP_XORI:  begin r.alu_operation = ALU_XOR; r.control_flags = G_IZ; end
				OP_LUI:   begin r.alu_operation = ALU_LUI; r.control_flags = G_I; end
				OP_LB:    begin r.memory_access = MEM_BYTE; r.control_flags = G_LD; end
				OP_LH:    begin r.memory_access = MEM_HALF; r.control_flags = G_LD; end
				OP_LW:    begin r.memory_access = MEM_WORD; r.control_flags = G_LD; end
				OP_LBU:   begin r.memory_access = MEM_BYTEU; r.control_flags = G_LD; end
				OP_LHU:   begin r.memory_access = MEM_HALFU; r.control_flags = G_LD; end
				OP_LWL, OP_LWR: r.control_flags = F_MEM;
				OP_SB:    begin r.memory_access = MEM_BYTE; r.control_flags = G_ST; end
				OP_SH:    begin r.memory_access = MEM_HALF; r.control_flags = G_ST; end
				OP_SW:    begin r.memory_access = MEM_WORD; r.control_flags = G_ST; end
				OP_SWL, OP_SWR: r.control_flags = F_MEM | F_MSTORE;
				OP_CACHE: begin
					r.memory_access = MEM_CACHE;
					r.control_flags = F_SUP | F_ALUSRC | F_MEM | F_MSTORE;
				end
				default:  begin r.format_class = FMT_UNKNOWN; r.alu_operation = ALU_SLL; end
			endcase
		end
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$error("decoded result with no item outstanding");
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					compare_field("format_class", want.format_class, out_ch.format_class);
					compare_field("alu_operation", want.alu_operation, out_ch.alu_operation);
					compare_field("memory_access", want.memory_access, out_ch.memory_access);
					compare_field("control_flags", want.control_flags, out_ch.control_flags);
					compare_field("source_reg", want.source_reg, out_ch.source_reg);
					compare_field("target_reg", want.target_reg, out_ch.target_reg);
					compare_field("dest_reg", want.dest_reg, out_ch.dest_reg);
					compare_field("shift_amount", want.shift_amount, out_ch.shift_amount);
					compare_field("immediate_value", want.immediate_value,
						out_ch.immediate_value);
					compare_field("jump_target", want.jump_target, out_ch.jump_target);
				end
			end
			if (in_ch.valid && in_ch.ready)
				decoded_q.push_back(decode_word(in_ch.instruction_word));
			pending = decoded_q.size();
		end
	end

endmodule

@@ test/tb_mips_instruction_decoder.sv @@
`timescale 1ns / 100ps
// Bench top for the MIPS instruction decoder: clock, reset, instruction stimulus and verdict.
// Depends on mid_pkg, mid_codes_pkg, the channel interfaces, mid_decode_checker and the block.
module tb_mips_instruction_decoder;
	import mid_pkg::*;
	import mid_codes_pkg::*;

	localparam int RANDOM_ITEMS = 1250;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;

	mid_in_if  req();
	mid_out_if rsp();

	mips_instruction_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mid_decode_checker decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (req),
		.out_ch     (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic offer_word(input logic [WORD_W-1:0] word, input bit may_idle);
		while (may_idle && $urandom_range(99) < 13) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.instruction_word <= word;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : result_drain
		int cyc;
		cyc = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			// hold off long enough to fill both registers and stall the input, later take every result, else take at random
			if (cyc >= 300 && cyc < 380)
				rsp.ready <= 1'b0;
			else if (cyc >= 900 && cyc < 1300)
				rsp.ready <= 1'b1;
			else
				rsp.ready <= ($urandom_range(99) >= 13);
		end
	end

	initial begin : word_source
		logic [WORD_W-1:0] directed_words[];
		logic [WORD_W-1:0] word;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.instruction_word = '0;
		directed_words = '{
			32'h0000_0000,
			32'hFFFF_FFFF,
			{OPC_SPECIAL, 20'hFFFFF, FN_ADD},
			{OPC_SPECIAL, 20'h00000, FN_PAST},
			{OPC_SPECIAL, 20'hA5A5A, FN_TOP},
			{OPC_SPECIAL, 20'h5A5A5, FN_MOVCI},
			{OPC_SPECIAL, 5'd31, 5'd0, 5'd31, 5'd0, FN_JALR},
			{OPC_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd31, FN_MULT},
			{OPC_SPECIAL, 20'h12345, FN_BREAK},
			{OPC_SPECIAL, 5'd0, 5'd31, 5'd3, 5'd31, FN_SRA},
			{OP_LWL, 26'h3FF_FFFF},
			{OP_LWR, 26'h000_0000},
			{OP_SWL, 5'd31, 5'd0, 16'h8000},
			{OP_SWR, 5'd0, 5'd31, 16'h7FFF},
			{OP_CACHE, 5'd4, 5'd5, 16'hFFFC},
			{OP_JAL, 26'h3FF_FFFF},
			{OP_J, 26'h000_0000},
			{OP_LUI, 5'd0, 5'd31, 16'hFFFF},
			{OP_ORI, 5'd31, 5'd31, 16'h0000},
			{OP_LBU, 5'd29, 5'd8, 16'hFFFF},
			{OP_SW, 5'd29, 5'd31, 16'h0004},
			{OP_BEQ, 5'd1, 5'd1, 16'hFFFE},
			{OP_REGIMM, 5'd7, 5'd17, 16'h0010},
			{OP_COP0, 26'h155_5555},
			{OP_ADDI, 5'd2, 5'd3, 16'h8000}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_words[i])
			offer_word(directed_words[i], 1'b1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			word = $urandom();
			// bias toward the funct table, which a uniform opcode rarely reaches
			if ($urandom_range(99) < 45)
				word[31:26] = OPC_SPECIAL;
			offer_word(word, !(n >= 500 && n < 800));
		end
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
